// File: rtl/core/lcets_pkg.sv
package lcets_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int FRAC_W    = 16;
  localparam int SMOOTH_W  = 40;
  localparam int ALPHA_W   = 17;
  localparam int RECIP_W   = 48;
  localparam int TIMEOUT_W = 16;
  localparam int GRAMS_W   = 32;
  localparam int STATUS_W  = 2;
  localparam int OP_W      = 2;

  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 104;
  localparam int OUT_USER_W = STATUS_W;

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 64;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [ALPHA_W-1:0]   ALPHA_ONE     = 17'h1_0000;
  localparam logic [ALPHA_W-1:0]   ALPHA_RESET   = 17'd6554;
  localparam logic [RECIP_W-1:0]   RECIP_RESET   = 48'd4294967;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd50;
  localparam logic [TIMEOUT_W-1:0] MISS_MAX      = 16'hFFFF;

  localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
  localparam logic [OP_W-1:0] OP_MISS   = 2'd1;
  localparam logic [OP_W-1:0] OP_TARE   = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_SAMPLE      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOT_READY   = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_TARE_DONE   = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_TARE_REJECT = 2'd3;

  localparam logic [1:0] REG_ALPHA   = 2'd0;
  localparam logic [1:0] REG_RECIP   = 2'd1;
  localparam logic [1:0] REG_TIMEOUT = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [SAMPLE_W-1:0] sample;
  } item_t;

  typedef struct packed {
    logic [ALPHA_W-1:0]   alpha;
    logic [RECIP_W-1:0]   recip;
    logic [TIMEOUT_W-1:0] timeout;
  } cfg_t;

  typedef struct packed {
    logic push;
    logic full;
  } q_ctl_t;

endpackage

// File: rtl/core/load_cell_ema_tare_scaler.sv
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  tdata: raw_bits; tuser: req_type, data_ready
// m_*      out  m_tvalid/m_tready  tdata: result values; tuser: status
// APB      in   psel/penable       ema_alpha @0x00, cal_reciprocal @0x08, timeout_polls @0x10
//
// Back end steps a blended sample through EMA, EMA_ADD, WHOLE, DIFF, MUL_LO, MUL_HI,
// SUM and DONE; a first sample, miss or tare skips EMA and EMA_ADD. Results load in
// DONE once the output is free. The shared 41x24 multiplier runs once for the
// average and twice for the gram scaling. Two-entry queue keeps input open while the
// back end works or the output stalls. Sync rst resets state, flags and config.
module load_cell_ema_tare_scaler import lcets_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,  // [23:0] raw_bits
  input  logic [IN_USER_W-1:0]  s_tuser,  // [0] req_type, [1] data_ready
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [23:0] raw_value, [47:24] smoothed_int, [79:48] grams_tenths, [80] is_ready,
  // [81] is_tared, [82] timeout_warning, [98:83] miss_count, [103:99] zero
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic [OUT_USER_W-1:0] m_tuser,  // [1:0] status
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t   cfg;
  q_ctl_t q_ctl;
  item_t  front_item;
  item_t  head_item;
  logic   q_full;
  logic   q_valid;
  logic   q_pop;

  lcets_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lcets_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_ctl    (q_ctl),
    .item     (front_item)
  );

  lcets_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .q_ctl     (q_ctl),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (head_item)
  );

  lcets_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_item   (head_item),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// File: rtl/core/lcets_regs.sv
module lcets_regs import lcets_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:3];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alpha   <= ALPHA_RESET;
      cfg.recip   <= RECIP_RESET;
      cfg.timeout <= TIMEOUT_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_ALPHA:   cfg.alpha   <= pwdata[ALPHA_W-1:0];
        REG_RECIP:   cfg.recip   <= pwdata[RECIP_W-1:0];
        REG_TIMEOUT: cfg.timeout <= pwdata[TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ALPHA:   prdata = {{(APB_DATA_W-ALPHA_W){1'b0}}, cfg.alpha};
      REG_RECIP:   prdata = {{(APB_DATA_W-RECIP_W){1'b0}}, cfg.recip};
      REG_TIMEOUT: prdata = {{(APB_DATA_W-TIMEOUT_W){1'b0}}, cfg.timeout};
      default:     prdata = '0;
    endcase
  end

endmodule

// File: rtl/core/lcets_front.sv
module lcets_front import lcets_pkg::*; (
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_DATA_W-1:0] s_tdata,
  input  logic [IN_USER_W-1:0] s_tuser,
  input  logic                 q_full,
  output q_ctl_t               q_ctl,
  output item_t                item
);

  logic req_tare;
  logic data_ready;

  assign req_tare   = s_tuser[0];
  assign data_ready = s_tuser[1];

  assign s_tready   = !q_full;
  assign q_ctl.push = s_tvalid && s_tready;
  assign q_ctl.full = q_full;

  // tare wins over the ready flag; raw word ignored for tare and misses
  always_comb begin
    item.sample = s_tdata[SAMPLE_W-1:0];
    if (req_tare) begin
      item.op = OP_TARE;
    end else if (data_ready) begin
      item.op = OP_SAMPLE;
    end else begin
      item.op = OP_MISS;
    end
  end

endmodule

// File: rtl/core/lcets_queue.sv
module lcets_queue import lcets_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  q_ctl_t q_ctl,
  input  item_t  push_item,
  output logic   full,
  input  logic   pop,
  output logic   valid,
  output item_t  head
);

  item_t             slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QDEPTH));
  assign valid = (count != '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (q_ctl.push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (q_ctl.push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (q_ctl.push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !q_ctl.push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_ctl.push |-> !q_ctl.full && (count < QCNT_W'(QDEPTH)))
    else $error("queue written while full");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("queue read while empty");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("queue count out of range");
`endif

endmodule

// File: rtl/core/lcets_back.sv
module lcets_back import lcets_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_t                  cfg,
  input  logic                  q_valid,
  input  item_t                 q_item,
  output logic                  q_pop,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic [OUT_USER_W-1:0] m_tuser
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_EMA     = 4'd1;
  localparam logic [3:0] S_EMA_ADD = 4'd2;
  localparam logic [3:0] S_WHOLE   = 4'd3;
  localparam logic [3:0] S_DIFF    = 4'd4;
  localparam logic [3:0] S_MUL_LO  = 4'd5;
  localparam logic [3:0] S_MUL_HI  = 4'd6;
  localparam logic [3:0] S_SUM     = 4'd7;
  localparam logic [3:0] S_DONE    = 4'd8;

  localparam int MUL_A_W = SMOOTH_W + 1;
  localparam int MUL_B_W = RECIP_W / 2;
  localparam int PROD_W  = 58;
  localparam int PART_W  = 52;
  localparam int MAG10_W = 28;
  localparam int DIFF_W  = SAMPLE_W + 1;
  localparam int GSUM_W  = PART_W + MUL_B_W + 1;
  localparam int MAG_W   = GSUM_W - 32;

  logic [3:0]          state;
  logic [OP_W-1:0]     op;
  logic [SAMPLE_W-1:0] sample;

  logic [SAMPLE_W-1:0]  last_raw;
  logic [SMOOTH_W-1:0]  smoothed;
  logic [SAMPLE_W-1:0]  tare_offset;
  logic                 seeded;
  logic                 tare_taken;
  logic [TIMEOUT_W-1:0] miss;
  logic                 warn;
  logic [STATUS_W-1:0]  status;

  logic [SAMPLE_W-1:0] whole;
  logic [PROD_W-1:0]   prod;
  logic [PART_W-1:0]   lo;
  logic [MAG10_W-1:0]  mag10;
  logic                neg;
  logic [MAG_W-1:0]    mag;

  logic [ALPHA_W-1:0]         alpha_eff;
  logic signed [MUL_A_W-1:0]  ema_delta;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]         mul_b;
  logic signed [MUL_A_W+MUL_B_W:0] mul_full;
  logic signed [PROD_W-1:0]   ema_round;
  logic [SMOOTH_W+1:0]        ema_new;
  logic [SMOOTH_W-1:0]        whole_round;
  logic [DIFF_W-1:0]          diff;
  logic [DIFF_W-1:0]          diff_abs;
  logic [MAG10_W-1:0]         mag10_calc;
  logic [GSUM_W-1:0]          gram_sum;
  logic [GRAMS_W-1:0]         grams;
  logic [TIMEOUT_W-1:0]       miss_inc;
  logic                       out_load;

  assign q_pop    = (state == S_IDLE) && q_valid;
  assign miss_inc = miss + TIMEOUT_W'(1);
  assign out_load = (state == S_DONE) && (!m_tvalid || m_tready);

  always_comb begin
    alpha_eff = (cfg.alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.alpha;
    // new = old + round(alpha * (S - old)), alpha in Q1.16
    ema_delta = $signed({sample[SAMPLE_W-1], sample, {FRAC_W{1'b0}}})
              - $signed({smoothed[SMOOTH_W-1], smoothed});
    case (state)
      S_EMA: begin
        mul_a = ema_delta;
        mul_b = {{(MUL_B_W-ALPHA_W){1'b0}}, alpha_eff};
      end
      S_MUL_LO: begin
        mul_a = $signed({{(MUL_A_W-MAG10_W){1'b0}}, mag10});
        mul_b = cfg.recip[MUL_B_W-1:0];
      end
      default: begin
        mul_a = $signed({{(MUL_A_W-MAG10_W){1'b0}}, mag10});
        mul_b = cfg.recip[RECIP_W-1:MUL_B_W];
      end
    endcase
    mul_full = mul_a * $signed({1'b0, mul_b});

    ema_round = $signed(prod) + $signed(PROD_W'(32768));
    ema_new   = {{2{smoothed[SMOOTH_W-1]}}, smoothed}
              + ema_round[PROD_W-1:FRAC_W];

    // truncate toward zero
    whole_round = smoothed + {{(SMOOTH_W-FRAC_W){1'b0}}, {FRAC_W{smoothed[SMOOTH_W-1]}}};

    diff       = {whole[SAMPLE_W-1], whole} - {tare_offset[SAMPLE_W-1], tare_offset};
    diff_abs   = diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;
    mag10_calc = {diff_abs, 3'b000} + {2'b00, diff_abs, 1'b0};

    gram_sum = {1'b0, prod[PART_W-1:0], {MUL_B_W{1'b0}}}
             + {{(GSUM_W-PART_W){1'b0}}, lo}
             + GSUM_W'(33'h0_8000_0000);

    if (neg) begin
      if (mag >= MAG_W'(33'h0_8000_0000)) begin
        grams = 32'h8000_0000;
      end else begin
        grams = ~mag[GRAMS_W-1:0] + GRAMS_W'(1);
      end
    end else begin
      if (mag > MAG_W'(32'h7FFF_FFFF)) begin
        grams = 32'h7FFF_FFFF;
      end else begin
        grams = mag[GRAMS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      last_raw    <= '0;
      smoothed    <= '0;
      tare_offset <= '0;
      seeded      <= 1'b0;
      tare_taken  <= 1'b0;
      miss        <= '0;
      warn        <= 1'b0;
      status      <= STAT_SAMPLE;
      whole       <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            op     <= q_item.op;
            sample <= q_item.sample;
            warn   <= 1'b0;
            state  <= S_WHOLE;
            case (q_item.op)
              OP_TARE: begin
                status <= seeded ? STAT_TARE_DONE : STAT_TARE_REJECT;
              end
              OP_SAMPLE: begin
                status   <= STAT_SAMPLE;
                miss     <= '0;
                last_raw <= q_item.sample;
                if (seeded) begin
                  state <= S_EMA;
                end else begin
                  smoothed <= {q_item.sample, {FRAC_W{1'b0}}};
                  seeded   <= 1'b1;
                end
              end
              default: begin
                status <= STAT_NOT_READY;
                if (miss != MISS_MAX) begin
                  miss <= miss_inc;
                  warn <= (miss_inc == cfg.timeout);
                end
              end
            endcase
          end
        end
        S_EMA: begin
          prod  <= mul_full[PROD_W-1:0];
          state <= S_EMA_ADD;
        end
        S_EMA_ADD: begin
          smoothed <= ema_new[SMOOTH_W-1:0];
          state    <= S_WHOLE;
        end
        S_WHOLE: begin
          whole <= whole_round[SMOOTH_W-1:FRAC_W];
          if (op == OP_TARE && seeded) begin
            tare_offset <= whole_round[SMOOTH_W-1:FRAC_W];
            tare_taken  <= 1'b1;
          end
          state <= S_DIFF;
        end
        S_DIFF: begin
          mag10 <= mag10_calc;
          neg   <= diff[DIFF_W-1];
          state <= S_MUL_LO;
        end
        S_MUL_LO: begin
          prod  <= mul_full[PROD_W-1:0];
          state <= S_MUL_HI;
        end
        S_MUL_HI: begin
          lo    <= prod[PART_W-1:0];
          prod  <= mul_full[PROD_W-1:0];
          state <= S_SUM;
        end
        S_SUM: begin
          mag   <= gram_sum[GSUM_W-1:32];
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            m_tuser  <= status;
            m_tdata  <= {{(OUT_DATA_W-99){1'b0}}, miss, warn, tare_taken, seeded,
                         grams, whole, last_raw};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_tare_needs_seed: assert property (@(posedge clk) disable iff (rst)
    tare_taken |-> seeded)
    else $error("tare captured without a sample");

  a_warn_has_misses: assert property (@(posedge clk) disable iff (rst)
    warn |-> (miss != '0) && (status == STAT_NOT_READY))
    else $error("timeout warning without misses");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && m_tvalid && !m_tready) |=> state == S_DONE)
    else $error("result overwritten while output stalled");
`endif

endmodule

// File: tb/tb_load_cell_ema_tare_scaler.sv
module tb_load_cell_ema_tare_scaler;
  timeunit 1ns;
  timeprecision 1ps;
  import lcets_pkg::*;

  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 300;
  localparam int PHASE_ITEMS    = 272;
  localparam int TAIL_ITEMS     = 40;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [SAMPLE_W-1:0]  raw_value;
    logic [SAMPLE_W-1:0]  smoothed_int;
    logic [GRAMS_W-1:0]   grams;
    logic                 is_ready;
    logic                 is_tared;
    logic                 warn;
    logic [TIMEOUT_W-1:0] miss;
  } lc_res_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e            kind;
    logic                 req_type;
    logic                 data_ready;
    logic [SAMPLE_W-1:0]  raw;
    bit                   typed;
    lc_res_t              res;
    logic [ALPHA_W-1:0]   alpha;
    logic [RECIP_W-1:0]   recip;
    logic [TIMEOUT_W-1:0] timeout;
  } lc_row_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;   // [23:0] raw_bits
  logic [IN_USER_W-1:0]  s_tuser;   // [0] req_type, [1] data_ready
  logic                  m_tvalid;
  logic                  m_tready;
  // [23:0] raw_value, [47:24] smoothed_int, [79:48] grams_tenths, [80] is_ready,
  // [81] is_tared, [82] timeout_warning, [98:83] miss_count, [103:99] zero
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;   // [1:0] status
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  load_cell_ema_tare_scaler uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor copy of registers and state
  logic [ALPHA_W-1:0]   c_alpha;
  logic [RECIP_W-1:0]   c_recip;
  logic [TIMEOUT_W-1:0] c_timeout;
  logic [SAMPLE_W-1:0]  p_last;
  longint               p_smooth;
  longint               p_tare;
  bit                   p_seeded;
  bit                   p_tared;
  logic [TIMEOUT_W-1:0] p_miss;

  lc_res_t expected_results[$];
  lc_row_t dir_rows[$];
  int      mismatch_count;
  int      quiet_cycles;
  bit      idle_on;
  bit      hold_request;
  bit      row_typed;
  lc_res_t row_exp;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic longint whole_of(longint s);
    if (s < 0) return -((-s) >>> FRAC_W);
    return s >>> FRAC_W;
  endfunction

  function automatic longint blend(longint old, longint smp);
    longint a;
    longint acc;
    if (c_alpha > ALPHA_ONE) a = 64'sd65536;
    else a = longint'(c_alpha);
    acc = a * (smp <<< FRAC_W) + (64'sd65536 - a) * old + 64'sd32768;
    return acc >>> 16;
  endfunction

  function automatic logic [GRAMS_W-1:0] scale_grams(longint diff);
    logic [127:0] mag;
    longint       absd;
    absd = (diff < 0) ? -diff : diff;
    mag = (128'(absd) * 128'd10 * 128'(c_recip) + 128'h8000_0000) >> 32;
    if (diff < 0) return (mag >= 128'h8000_0000) ? 32'h8000_0000 : 32'd0 - mag[31:0];
    return (mag > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
  endfunction

  function automatic lc_res_t weigh_item(logic rt, logic dr, logic [SAMPLE_W-1:0] raw);
    lc_res_t r;
    longint  w;
    r = '0;
    if (rt) begin
      if (p_seeded) begin
        p_tare = whole_of(p_smooth);
        p_tared = 1'b1;
        r.status = STAT_TARE_DONE;
      end else begin
        r.status = STAT_TARE_REJECT;
      end
    end else if (dr) begin
      p_miss = '0;
      p_last = raw;
      if (!p_seeded) begin
        p_smooth = longint'($signed(raw)) <<< FRAC_W;
        p_seeded = 1'b1;
      end else begin
        p_smooth = blend(p_smooth, longint'($signed(raw)));
      end
      r.status = STAT_SAMPLE;
    end else begin
      if (p_miss != MISS_MAX) begin
        p_miss = p_miss + 1'b1;
        r.warn = (p_miss == c_timeout);
      end
      r.status = STAT_NOT_READY;
    end
    w = whole_of(p_smooth);
    r.raw_value = p_last;
    r.smoothed_int = w[SAMPLE_W-1:0];
    r.grams = scale_grams(w - p_tare);
    r.is_ready = p_seeded;
    r.is_tared = p_tared;
    r.miss = p_miss;
    return r;
  endfunction

  function automatic string fmt_res(lc_res_t r);
    return $sformatf("st=%0d raw=%0d sm=%0d g=%0d rdy=%0b tared=%0b warn=%0b miss=%0d",
                     r.status, $signed(r.raw_value), $signed(r.smoothed_int),
                     $signed(r.grams), r.is_ready, r.is_tared, r.warn, r.miss);
  endfunction

  function automatic void check_result(lc_res_t got);
    lc_res_t want;
    if (expected_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10) $display("unexpected result: %s", fmt_res(got));
      return;
    end
    want = expected_results.pop_front();
    if (got.status !== want.status || got.raw_value !== want.raw_value ||
        got.smoothed_int !== want.smoothed_int || got.grams !== want.grams ||
        got.is_ready !== want.is_ready || got.is_tared !== want.is_tared ||
        got.warn !== want.warn || got.miss !== want.miss) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("result mismatch at %0t", $realtime);
        $display("  expected %s", fmt_res(want));
        $display("  actual   %s", fmt_res(got));
      end
    end
  endfunction

  always @(posedge clk) begin : monitor
    lc_res_t got;
    lc_res_t pred;
    bit      moved;
    if (rst) begin
      c_alpha = ALPHA_RESET;
      c_recip = RECIP_RESET;
      c_timeout = TIMEOUT_RESET;
      p_last = '0;
      p_smooth = 0;
      p_tare = 0;
      p_seeded = 1'b0;
      p_tared = 1'b0;
      p_miss = '0;
      quiet_cycles = 0;
    end else begin
      moved = 1'b0;
      if (psel && penable && pwrite && pready) begin
        moved = 1'b1;
        case (paddr[4:3])
          REG_ALPHA:   c_alpha = pwdata[ALPHA_W-1:0];
          REG_RECIP:   c_recip = pwdata[RECIP_W-1:0];
          REG_TIMEOUT: c_timeout = pwdata[TIMEOUT_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        moved = 1'b1;
        pred = weigh_item(s_tuser[0], s_tuser[1], s_tdata[SAMPLE_W-1:0]);
        expected_results.push_back(row_typed ? row_exp : pred);
      end
      if (m_tvalid && m_tready) begin
        moved = 1'b1;
        got.status = m_tuser;
        got.raw_value = m_tdata[23:0];
        got.smoothed_int = m_tdata[47:24];
        got.grams = m_tdata[79:48];
        got.is_ready = m_tdata[80];
        got.is_tared = m_tdata[81];
        got.warn = m_tdata[82];
        got.miss = m_tdata[98:83];
        check_result(got);
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // receiver side
  initial begin
    m_tready = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        m_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic send_item(logic rt, logic dr, logic [SAMPLE_W-1:0] raw, bit typed,
                           lc_res_t ex);
    int gap;
    gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 10) : 0;
    @(negedge clk);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= raw;
    s_tuser <= {dr, rt};
    row_typed <= typed;
    row_exp <= ex;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic apb_write(logic [1:0] idx, logic [APB_DATA_W-1:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // drains the block to idle before the register writes
  task automatic set_config(logic [ALPHA_W-1:0] a, logic [RECIP_W-1:0] r,
                            logic [TIMEOUT_W-1:0] t);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    apb_write(REG_ALPHA, APB_DATA_W'(a));
    apb_write(REG_RECIP, APB_DATA_W'(r));
    apb_write(REG_TIMEOUT, APB_DATA_W'(t));
  endtask

  function automatic lc_res_t mk_res(logic [STATUS_W-1:0] st, int raw, int sm,
                                     logic [GRAMS_W-1:0] g, int rdy, int tared, int warn,
                                     int miss);
    lc_res_t r;
    r.status = st;
    r.raw_value = raw[SAMPLE_W-1:0];
    r.smoothed_int = sm[SAMPLE_W-1:0];
    r.grams = g;
    r.is_ready = rdy[0];
    r.is_tared = tared[0];
    r.warn = warn[0];
    r.miss = miss[TIMEOUT_W-1:0];
    return r;
  endfunction

  function automatic void add_chk(int rt, int dr, logic [SAMPLE_W-1:0] raw, int typed,
                                  lc_res_t ex);
    lc_row_t row;
    row = '{kind: ROW_ITEM, req_type: rt[0], data_ready: dr[0], raw: raw, typed: typed[0],
            res: ex, alpha: '0, recip: '0, timeout: '0};
    dir_rows.push_back(row);
  endfunction

  function automatic void add_item(int rt, int dr, logic [SAMPLE_W-1:0] raw);
    add_chk(rt, dr, raw, 0, '0);
  endfunction

  function automatic void add_cfg(logic [ALPHA_W-1:0] a, logic [RECIP_W-1:0] r,
                                  logic [TIMEOUT_W-1:0] t);
    lc_row_t row;
    row = '{kind: ROW_CFG, req_type: 1'b0, data_ready: 1'b0, raw: '0, typed: 1'b0,
            res: '0, alpha: a, recip: r, timeout: t};
    dir_rows.push_back(row);
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_raw();
    int v;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0: return 24'h800000;
          1: return 24'h7FFFFF;
          2: return 24'h000000;
          default: return 24'hFFFFFF;
        endcase
      end
      1, 2: begin
        v = int'($urandom_range(0, 2000)) - 1000;
        return v[SAMPLE_W-1:0];
      end
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [RECIP_W-1:0] rand_recip();
    return {16'($urandom_range(0, 16'hFFFF)), 32'($urandom)};
  endfunction

  initial begin : stimulus
    lc_row_t row;
    int      n;
    int      k;
    int      burst;
    bit      held;
    bit      paused;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    row_typed = 1'b0;
    row_exp = '0;
    idle_on = 1'b1;
    hold_request = 1'b0;
    mismatch_count = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset values: tare refused before the first sample, misses counted
    add_chk(1, 1, 24'hFFFFFF, 1, mk_res(STAT_TARE_REJECT, 0, 0, 0, 0, 0, 0, 0));
    add_chk(0, 0, 24'h5A5A5A, 1, mk_res(STAT_NOT_READY, 0, 0, 0, 0, 0, 0, 1));
    add_chk(0, 0, 24'hA5A5A5, 1, mk_res(STAT_NOT_READY, 0, 0, 0, 0, 0, 0, 2));
    add_chk(1, 0, 24'h000000, 1, mk_res(STAT_TARE_REJECT, 0, 0, 0, 0, 0, 0, 2));
    add_item(0, 1, 24'h7FFFFF);
    add_item(0, 1, 24'h800000);
    add_item(0, 1, 24'h000000);
    add_item(1, 0, 24'h123456);
    add_item(0, 0, 24'hFFFFFF);
    // unity weight and one count per gram: values read straight off
    add_cfg(ALPHA_ONE, 48'h1_0000_0000, 16'd3);
    add_item(0, 1, 24'h000000);
    add_chk(1, 1, 24'h7FFFFF, 1, mk_res(STAT_TARE_DONE, 0, 0, 0, 1, 1, 0, 0));
    add_chk(0, 1, 24'd100, 1, mk_res(STAT_SAMPLE, 100, 100, 1000, 1, 1, 0, 0));
    add_chk(0, 1, 24'h800000, 1,
            mk_res(STAT_SAMPLE, -8388608, -8388608, -83886080, 1, 1, 0, 0));
    add_chk(0, 1, 24'h7FFFFF, 1,
            mk_res(STAT_SAMPLE, 8388607, 8388607, 83886070, 1, 1, 0, 0));
    add_chk(0, 0, 24'h000000, 1,
            mk_res(STAT_NOT_READY, 8388607, 8388607, 83886070, 1, 1, 0, 1));
    add_chk(0, 0, 24'hFFFFFF, 1,
            mk_res(STAT_NOT_READY, 8388607, 8388607, 83886070, 1, 1, 0, 2));
    add_chk(0, 0, 24'h000000, 1,
            mk_res(STAT_NOT_READY, 8388607, 8388607, 83886070, 1, 1, 1, 3));
    add_chk(0, 0, 24'h000000, 1,
            mk_res(STAT_NOT_READY, 8388607, 8388607, 83886070, 1, 1, 0, 4));
    // alpha above one, largest reciprocal: grams saturate; zero timeout never warns
    add_cfg(17'h1FFFF, 48'hFFFF_FFFF_FFFF, 16'd0);
    add_chk(0, 1, 24'h800000, 1,
            mk_res(STAT_SAMPLE, -8388608, -8388608, 32'h8000_0000, 1, 1, 0, 0));
    add_chk(0, 1, 24'h7FFFFF, 1,
            mk_res(STAT_SAMPLE, 8388607, 8388607, 32'h7FFF_FFFF, 1, 1, 0, 0));
    add_item(0, 0, 24'h000000);
    add_cfg(17'd0, 48'd0, 16'd1);
    add_item(0, 1, 24'h123456);
    add_item(0, 0, 24'hFFFFFF);
    add_item(1, 1, 24'h000000);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.kind == ROW_CFG) set_config(row.alpha, row.recip, row.timeout);
      else send_item(row.req_type, row.data_ready, row.raw, row.typed, row.res);
    end

    held = 1'b0;
    paused = 1'b0;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: set_config(ALPHA_W'($urandom_range(0, 65536)), rand_recip(),
                      TIMEOUT_W'($urandom_range(1, 12)));
        1: set_config(ALPHA_ONE, {16'h0, 32'($urandom)}, 16'd1);
        2: set_config(ALPHA_W'($urandom_range(65537, 17'h1FFFF)), rand_recip(), 16'd0);
        default: set_config(ALPHA_W'($urandom_range(0, 255)), {16'h0, 32'($urandom)},
                            TIMEOUT_W'($urandom_range(2, 12)));
      endcase
      n = 0;
      while (n < PHASE_ITEMS) begin
        if (p == 1 && !held && n >= 60) begin
          held = 1'b1;
          hold_request = 1'b1;
        end
        if (p == 2 && !paused && n >= 120) begin
          paused = 1'b1;
          wait_drained();
        end
        k = $urandom_range(0, 99);
        if (k < 8) begin
          burst = $urandom_range(1, 14);
          repeat (burst) send_item(1'b0, 1'b0, SAMPLE_W'($urandom), 1'b0, '0);
          n += burst;
        end else if (k < 18) begin
          send_item(1'b1, 1'($urandom_range(0, 1)), SAMPLE_W'($urandom), 1'b0, '0);
          n++;
        end else if (k < 30) begin
          send_item(1'b0, 1'b0, SAMPLE_W'($urandom), 1'b0, '0);
          n++;
        end else begin
          send_item(1'b0, 1'b1, rand_raw(), 1'b0, '0);
          n++;
        end
      end
    end

    // no idling from here on
    set_config(ALPHA_W'($urandom_range(0, 65536)), rand_recip(),
               TIMEOUT_W'($urandom_range(1, 12)));
    idle_on = 1'b0;
    send_item(1'b0, 1'b1, rand_raw(), 1'b0, '0);
    repeat (TAIL_ITEMS) begin
      k = $urandom_range(0, 3);
      send_item((k == 3), (k != 0), rand_raw(), 1'b0, '0);
    end
    send_item(1'b1, 1'b0, rand_raw(), 1'b0, '0);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/lcets_pkg.sv
rtl/core/lcets_regs.sv
rtl/core/lcets_front.sv
rtl/core/lcets_queue.sv
rtl/core/lcets_back.sv
rtl/core/load_cell_ema_tare_scaler.sv
tb/tb_load_cell_ema_tare_scaler.sv
